[src/qpm_pkg.sv]
// ----------------------------------------------------------------------------
// qpm_pkg
// Shared types, constants and register map for the quadrotor PID mixer core.
// ----------------------------------------------------------------------------
`default_nettype none

package qpm_pkg;

    localparam int P_DIV = 256;
    localparam int I_DIV = 256;
    localparam int D_DIV = 256;

    localparam int SUM_W = 48;

    typedef logic signed [15:0]      t_s16;
    typedef logic signed [31:0]      t_acc;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic        [11:0]      t_motor;
    typedef logic        [2:0]       t_cfg_idx;
    typedef logic        [30:0]      t_cfg_data;

    localparam t_motor OUT_MIN    = 12'd100;
    localparam t_motor OUT_MAX    = 12'd4000;
    localparam t_s16   TILT_LIMIT = 16'sd3640;

    localparam t_cfg_idx REG_PROP_GAIN    = 3'd0;
    localparam t_cfg_idx REG_INTEG_GAIN   = 3'd1;
    localparam t_cfg_idx REG_DERIV_GAIN   = 3'd2;
    localparam t_cfg_idx REG_PROP_LIMIT   = 3'd3;
    localparam t_cfg_idx REG_DERIV_LIMIT  = 3'd4;
    localparam t_cfg_idx REG_ACCUM_LIMIT  = 3'd5;
    localparam t_cfg_idx REG_THROTTLE_MIN = 3'd6;
    localparam t_cfg_idx REG_THROTTLE_MAX = 3'd7;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [15:0] deriv_gain;
        logic [14:0] prop_limit;
        logic [14:0] deriv_limit;
        logic [30:0] accum_limit;
        logic [11:0] throttle_min;
        logic [11:0] throttle_max;
    } t_cfg;

endpackage

`default_nettype wire

[src/qpm_cfg.sv]
// ----------------------------------------------------------------------------
// qpm_cfg
// Configuration register file: gains, term limits and throttle window.
// ----------------------------------------------------------------------------
`default_nettype none

module qpm_cfg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire qpm_pkg::t_cfg_idx  i_cfg_idx,
    input  wire qpm_pkg::t_cfg_data i_cfg_data,
    output qpm_pkg::t_cfg           o_cfg
);
    import qpm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain    <= '0;
            r_cfg.integ_gain   <= '0;
            r_cfg.deriv_gain   <= '0;
            r_cfg.prop_limit   <= '1;
            r_cfg.deriv_limit  <= '1;
            r_cfg.accum_limit  <= '1;
            r_cfg.throttle_min <= '0;
            r_cfg.throttle_max <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PROP_GAIN:    r_cfg.prop_gain    <= i_cfg_data[15:0];
                REG_INTEG_GAIN:   r_cfg.integ_gain   <= i_cfg_data[15:0];
                REG_DERIV_GAIN:   r_cfg.deriv_gain   <= i_cfg_data[15:0];
                REG_PROP_LIMIT:   r_cfg.prop_limit   <= i_cfg_data[14:0];
                REG_DERIV_LIMIT:  r_cfg.deriv_limit  <= i_cfg_data[14:0];
                REG_ACCUM_LIMIT:  r_cfg.accum_limit  <= i_cfg_data[30:0];
                REG_THROTTLE_MIN: r_cfg.throttle_min <= i_cfg_data[11:0];
                REG_THROTTLE_MAX: r_cfg.throttle_max <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[src/qpm_axis.sv]
// ----------------------------------------------------------------------------
// qpm_axis
// One control axis: integrator update with clamp, clamped P and D terms,
// scaled I term, and their sum.
// ----------------------------------------------------------------------------
`default_nettype none

module qpm_axis (
    input  wire qpm_pkg::t_s16 i_err,
    input  wire qpm_pkg::t_s16 i_rate,
    input  wire logic          i_rate_neg,
    input  wire qpm_pkg::t_acc i_acc,
    input  wire logic          i_acc_en,
    input  wire qpm_pkg::t_cfg i_cfg,
    output qpm_pkg::t_acc      o_acc,
    output qpm_pkg::t_sum      o_sum
);
    import qpm_pkg::*;

    function automatic logic signed [32:0] clamp_term(logic signed [32:0] v,
                                                      logic [14:0] lim);
        logic signed [32:0] hi;
        hi = $signed({18'd0, lim});
        if (v > hi)       return hi;
        else if (v < -hi) return -hi;
        else              return v;
    endfunction

    logic signed [32:0] acc_add;
    logic signed [32:0] acc_sum;
    logic signed [32:0] acc_lim;
    t_acc               acc_new;
    logic signed [48:0] prod_i;
    logic signed [48:0] term_i;
    logic signed [32:0] prod_p;
    logic signed [32:0] term_p;
    logic signed [32:0] prod_d;
    logic signed [32:0] quot_d;
    logic signed [32:0] term_d;

    always_comb begin
        acc_add = i_acc_en ? 33'(i_err) : '0;
        acc_sum = 33'(i_acc) + acc_add;
        acc_lim = $signed({2'b00, i_cfg.accum_limit});
        if (acc_sum > acc_lim)       acc_new = acc_lim[31:0];
        else if (acc_sum < -acc_lim) acc_new = 32'(-acc_lim);
        else                         acc_new = acc_sum[31:0];

        prod_i = $signed({1'b0, i_cfg.integ_gain}) * acc_new;
        term_i = prod_i / I_DIV;

        prod_p = $signed({1'b0, i_cfg.prop_gain}) * i_err;
        term_p = clamp_term(prod_p / P_DIV, i_cfg.prop_limit);

        prod_d = $signed({1'b0, i_cfg.deriv_gain}) * i_rate;
        quot_d = prod_d / D_DIV;
        term_d = clamp_term(i_rate_neg ? -quot_d : quot_d, i_cfg.deriv_limit);
    end

    assign o_acc = acc_new;
    assign o_sum = SUM_W'(term_i) + SUM_W'(term_p) + SUM_W'(term_d);

endmodule

`default_nettype wire

[src/quadrotor_pid_mixer_core.sv]
// ----------------------------------------------------------------------------
// quadrotor_pid_mixer_core
// Attitude PID for pitch, roll and yaw with an X-frame motor mixer.
//
//   channel   direction  handshake                   word
//   in        sink       i_in_valid / o_in_ready     errors, gyro rates, throttle
//   out       source     o_out_valid / i_out_ready   four motor drives, throttle
//   cfg       sink       i_cfg_we                    register index and data
//
// Input register, then one pass to the result register.
// One word per cycle while the result is not stalled; the integrators close their loop within the pass.
// A stalled result holds while one more word waits in the input register.
// Reset clears the integrators and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrotor_pid_mixer_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire qpm_pkg::t_cfg_idx  i_cfg_idx,
    input  wire qpm_pkg::t_cfg_data i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire qpm_pkg::t_s16      i_pitch_err,
    input  wire qpm_pkg::t_s16      i_roll_err,
    input  wire qpm_pkg::t_s16      i_yaw_err,
    input  wire qpm_pkg::t_s16      i_rate_x,
    input  wire qpm_pkg::t_s16      i_rate_y,
    input  wire qpm_pkg::t_s16      i_rate_z,
    input  wire qpm_pkg::t_s16      i_throttle,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output qpm_pkg::t_motor         o_motor_a,
    output qpm_pkg::t_motor         o_motor_b,
    output qpm_pkg::t_motor         o_motor_c,
    output qpm_pkg::t_motor         o_motor_d,
    output qpm_pkg::t_s16           o_throttle_used
);
    import qpm_pkg::*;

    function automatic logic in_tilt(t_s16 v);
        return (v <= TILT_LIMIT) && (v >= -TILT_LIMIT);
    endfunction

    function automatic t_motor motor_clamp(t_sum v);
        t_sum lo;
        t_sum hi;
        lo = $signed({{(SUM_W-12){1'b0}}, OUT_MIN});
        hi = $signed({{(SUM_W-12){1'b0}}, OUT_MAX});
        if (v < lo)      return OUT_MIN;
        else if (v > hi) return OUT_MAX;
        else             return v[11:0];
    endfunction

    t_cfg cfg;

    qpm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // input register
    logic r_v1;
    logic n_v1;
    t_s16 r_pe, r_re, r_ye, r_gx, r_gy, r_gz, r_thr;

    // integrators
    t_acc r_pitch_acc, r_roll_acc, r_yaw_acc;

    // result register
    logic   r_v2;
    t_motor r_ma, r_mb, r_mc, r_md;
    t_s16   r_thr_used;

    logic adv;
    logic fire;
    logic take;

    assign adv        = !r_v2 || i_out_ready;
    assign fire       = r_v1 && adv;
    assign o_in_ready = !r_v1 || adv;
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        if (take)      n_v1 = 1'b1;
        else if (fire) n_v1 = 1'b0;
        else           n_v1 = r_v1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pe  <= i_pitch_err;
            r_re  <= i_roll_err;
            r_ye  <= i_yaw_err;
            r_gx  <= i_rate_x;
            r_gy  <= i_rate_y;
            r_gz  <= i_rate_z;
            r_thr <= i_throttle;
        end
    end

    // single pass
    logic               low;
    logic signed [16:0] thr_ext;
    logic signed [16:0] thr_cap;
    logic               tilt_ok;
    logic               yaw_ok;
    t_acc               pitch_acc_new, roll_acc_new, yaw_acc_new;
    t_sum               sum_p, sum_r, sum_y;
    t_sum               thr_s, sy;
    t_sum               mix_a, mix_b, mix_c, mix_d;

    always_comb begin
        thr_ext = 17'(r_thr);
        low     = thr_ext < $signed({5'd0, cfg.throttle_min});
        if (thr_ext > $signed({5'd0, cfg.throttle_max}))
            thr_cap = $signed({5'd0, cfg.throttle_max});
        else
            thr_cap = thr_ext;
        tilt_ok = in_tilt(r_pe) && in_tilt(r_re);
        yaw_ok  = tilt_ok && in_tilt(r_ye);
    end

    qpm_axis u_pitch (
        .i_err      (r_pe),
        .i_rate     (r_gy),
        .i_rate_neg (1'b1),
        .i_acc      (r_pitch_acc),
        .i_acc_en   (tilt_ok),
        .i_cfg      (cfg),
        .o_acc      (pitch_acc_new),
        .o_sum      (sum_p)
    );

    qpm_axis u_roll (
        .i_err      (r_re),
        .i_rate     (r_gx),
        .i_rate_neg (1'b0),
        .i_acc      (r_roll_acc),
        .i_acc_en   (tilt_ok),
        .i_cfg      (cfg),
        .o_acc      (roll_acc_new),
        .o_sum      (sum_r)
    );

    qpm_axis u_yaw (
        .i_err      (r_ye),
        .i_rate     (r_gz),
        .i_rate_neg (1'b1),
        .i_acc      (r_yaw_acc),
        .i_acc_en   (yaw_ok),
        .i_cfg      (cfg),
        .o_acc      (yaw_acc_new),
        .o_sum      (sum_y)
    );

    always_comb begin
        thr_s = SUM_W'(thr_cap);
        sy    = sum_y <<< 2;
        mix_a = thr_s - sum_p - sum_r + sy;
        mix_b = thr_s + sum_p - sum_r - sy;
        mix_c = thr_s + sum_p + sum_r + sy;
        mix_d = thr_s - sum_p + sum_r - sy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch_acc <= '0;
            r_roll_acc  <= '0;
            r_yaw_acc   <= '0;
        end else if (fire && !low) begin
            r_pitch_acc <= pitch_acc_new;
            r_roll_acc  <= roll_acc_new;
            r_yaw_acc   <= yaw_acc_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            if (low) begin
                r_ma       <= '0;
                r_mb       <= '0;
                r_mc       <= '0;
                r_md       <= '0;
                r_thr_used <= r_thr;
            end else begin
                r_ma       <= motor_clamp(mix_a);
                r_mb       <= motor_clamp(mix_b);
                r_mc       <= motor_clamp(mix_c);
                r_md       <= motor_clamp(mix_d);
                r_thr_used <= thr_cap[15:0];
            end
        end
    end

    assign o_out_valid     = r_v2;
    assign o_motor_a       = r_ma;
    assign o_motor_b       = r_mb;
    assign o_motor_c       = r_mc;
    assign o_motor_d       = r_md;
    assign o_throttle_used = r_thr_used;

    // motors are either all off or all inside the drive window
    a_motor_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_motor_a == '0) && (o_motor_b == '0) &&
             (o_motor_c == '0) && (o_motor_d == '0)) ||
            ((o_motor_a >= OUT_MIN) && (o_motor_a <= OUT_MAX) &&
             (o_motor_b >= OUT_MIN) && (o_motor_b <= OUT_MAX) &&
             (o_motor_c >= OUT_MIN) && (o_motor_c <= OUT_MAX) &&
             (o_motor_d >= OUT_MIN) && (o_motor_d <= OUT_MAX)))
        else $error("motor drive outside window");

    a_acc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && (!fire || low) |=>
            $stable(r_pitch_acc) && $stable(r_roll_acc) && $stable(r_yaw_acc))
        else $error("integrator moved without an update");

    a_out_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_v1))
        else $error("result valid without a word in the input register");

    a_acc_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !low |->
            (pitch_acc_new <= $signed({1'b0, cfg.accum_limit})) &&
            (pitch_acc_new >= -$signed({1'b0, cfg.accum_limit})))
        else $error("pitch integrator beyond limit");

endmodule

`default_nettype wire
